// ===== rtl/core/mutex_fifo_wait_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Mutex wait queue assertion macros
// Shared property forms for the checker of the mutex wait queue core.
// ----------------------------------------------------------------------------
`ifndef MUTEX_FIFO_WAIT_QUEUE_CORE_DEFINES_SVH
`define MUTEX_FIFO_WAIT_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define MFQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfq assertion failed: %m");

// next-cycle implication
`define MFQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfq assertion failed: %m");

`endif

// ===== rtl/core/mfq_pkg.sv =====
// ----------------------------------------------------------------------------
// Mutex wait queue package
// Field widths, action and status codes, result record.
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int ACTION_W            = 3;
    localparam int TID_W               = 8;
    localparam int STATUS_W            = 3;
    localparam int QUEUE_DEPTH_DEF     = 16;
    localparam int THREAD_ID_BITS_DEF  = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT    = 3'd0,
        ACT_TRYLOCK = 3'd1,
        ACT_LOCK    = 3'd2,
        ACT_UNLOCK  = 3'd3,
        ACT_REMOVE  = 3'd4,
        ACT_DESTROY = 3'd5
    } action_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_BUSY     = 3'd1,
        ST_QUEUED   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_TERM     = 3'd5
    } status_e;

    typedef struct packed {
        status_e          status;
        logic             thread_valid;
        logic [TID_W-1:0] thread_out;
        logic             last;
    } res_t;

endpackage

// ===== rtl/core/mfq_req_if.sv =====
// ----------------------------------------------------------------------------
// Mutex wait queue request channel
// Valid/ready channel carrying one request per transfer.
// ----------------------------------------------------------------------------
interface mfq_req_if;
    import mfq_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TID_W-1:0]    thread_id;

    modport source (output valid, action, thread_id, input ready);
    modport sink   (input valid, action, thread_id, output ready);

endinterface

// ===== rtl/core/mfq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Mutex wait queue result channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface mfq_rsp_if;
    import mfq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                thread_valid;
    logic [TID_W-1:0]    thread_out;
    logic                last;

    modport source (output valid, status, thread_valid, thread_out, last, input ready);
    modport sink   (input valid, status, thread_valid, thread_out, last, output ready);

endinterface

// ===== rtl/core/mfq_queue_ram.sv =====
// ----------------------------------------------------------------------------
// Mutex wait queue storage
// Single write port, single read port, registered read data held when idle.
// ----------------------------------------------------------------------------
module mfq_queue_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/mfq_seq.sv =====
// ----------------------------------------------------------------------------
// Mutex wait queue sequencer
// Lock flag, ring pointers and the read-modify-write walks over the queue.
// ----------------------------------------------------------------------------
module mfq_seq #(
    parameter int DEPTH = 16,
    parameter int IDW   = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    mfq_req_if.sink        req,
    output logic           ram_we,
    output logic [AW-1:0]  ram_waddr,
    output logic [IDW-1:0] ram_wdata,
    output logic           ram_re,
    output logic [AW-1:0]  ram_raddr,
    input  logic [IDW-1:0] ram_rdata,
    output logic           res_valid,
    input  logic           res_ready,
    output mfq_pkg::res_t  res
);
    import mfq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_POP   = 6'b000010,
        S_SRCH  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_DRAIN = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic           free_reg, free_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [IDW-1:0] tid_reg, tid_next;
    status_e        status_reg, status_next;

    logic [AW:0]    tail_sum;
    logic [AW-1:0]  tail;
    logic [AW-1:0]  pos_n;
    logic [AW-1:0]  pos_nn;
    logic [CW-1:0]  k_inc;
    logic           k_last;
    logic [IDW-1:0] tid_in;
    action_e        act;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    assign tail_sum = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : AW'(tail_sum);
    assign pos_n    = wrap_inc(pos_reg);
    assign pos_nn   = wrap_inc(pos_n);
    assign k_inc    = k_reg + CW'(1);
    assign k_last   = (k_inc == count_reg);
    assign tid_in   = IDW'(req.thread_id);
    assign act      = action_e'(req.action);

    always_comb
    begin
        state_next  = state_reg;
        free_next   = free_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        tid_next    = tid_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = tail;
        ram_wdata   = tid_in;
        ram_re      = 1'b0;
        ram_raddr   = head_reg;
        res_valid   = 1'b0;
        res         = '{status: ST_DONE, thread_valid: 1'b0, thread_out: '0, last: 1'b1};
        req.ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = res_ready;
                if (req.valid && res_ready)
                begin
                    unique case (act)
                        ACT_INIT:
                        begin
                            free_next  = 1'b1;
                            count_next = '0;
                            res_valid  = 1'b1;
                        end
                        ACT_TRYLOCK:
                        begin
                            res_valid = 1'b1;
                            if (free_reg)
                            begin
                                free_next = 1'b0;
                            end
                            else
                            begin
                                res.status = ST_BUSY;
                            end
                        end
                        ACT_LOCK:
                        begin
                            res_valid = 1'b1;
                            if (free_reg)
                            begin
                                free_next = 1'b0;
                            end
                            else if (count_reg != CW'(DEPTH))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                res.status = ST_QUEUED;
                            end
                            else
                            begin
                                res.status = ST_FULL;
                            end
                        end
                        ACT_UNLOCK:
                        begin
                            free_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                head_next  = wrap_inc(head_reg);
                                count_next = count_reg - CW'(1);
                                state_next = S_POP;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                pos_next   = head_reg;
                                k_next     = '0;
                                tid_next   = tid_in;
                                state_next = S_SRCH;
                            end
                        end
                        ACT_DESTROY:
                        begin
                            free_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                pos_next   = head_reg;
                                k_next     = '0;
                                state_next = S_DRAIN;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_valid        = 1'b1;
                res.thread_valid = 1'b1;
                res.thread_out   = TID_W'(ram_rdata);
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SRCH:
            begin
                if (ram_rdata == tid_reg)
                begin
                    if (k_last)
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = ST_DONE;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = pos_n;
                        k_next     = k_inc;
                        state_next = S_SHIFT;
                    end
                end
                else if (k_last)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_EMIT;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_n;
                    pos_next  = pos_n;
                    k_next    = k_inc;
                end
            end
            S_SHIFT:
            begin
                // entry at pos_n moves up one place into pos
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = ram_rdata;
                pos_next  = pos_n;
                if (k_last)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_DONE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_nn;
                    k_next    = k_inc;
                end
            end
            S_DRAIN:
            begin
                res_valid        = 1'b1;
                res.status       = ST_TERM;
                res.thread_valid = 1'b1;
                res.thread_out   = TID_W'(ram_rdata);
                res.last         = k_last;
                if (res_ready)
                begin
                    if (k_last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_n;
                        pos_next  = pos_n;
                        k_next    = k_inc;
                    end
                end
            end
            S_EMIT:
            begin
                res_valid  = 1'b1;
                res.status = status_reg;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            free_reg  <= 1'b1;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        tid_reg    <= tid_next;
        status_reg <= status_next;
    end

endmodule

// ===== rtl/core/mfq_out_buf.sv =====
// ----------------------------------------------------------------------------
// Mutex wait queue output register
// One-entry result register that decouples the result channel.
// ----------------------------------------------------------------------------
module mfq_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mfq_pkg::res_t in_res,
    mfq_rsp_if.source     rsp
);
    import mfq_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg, data_next;

    assign in_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                data_next = in_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign rsp.valid        = valid_reg;
    assign rsp.status       = data_reg.status;
    assign rsp.thread_valid = data_reg.thread_valid;
    assign rsp.thread_out   = data_reg.thread_out;
    assign rsp.last         = data_reg.last;

endmodule

// ===== rtl/core/mutex_fifo_wait_queue_core.sv =====
// Result path: init, trylock, lock, unlock on an empty queue: result registered in the output
// buffer at the transfer. Unlock with waiters: head read from the queue RAM, then reported.
// Destroy: head read, then one result per cycle while the output buffer accepts. Remove: search,
// then shift, over the single read port. Throughput: one request per cycle while results are
// accepted, for actions with no RAM walk; otherwise the next request waits for the walk to finish.
// Reset: asynchronous, mutex free and queue empty at once; queue RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Mutex with FIFO wait queue
// Hardware mutex whose waiting thread ids sit in a ring buffer RAM.
// ----------------------------------------------------------------------------
module mutex_fifo_wait_queue_core #(
    parameter int QUEUE_DEPTH    = mfq_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = mfq_pkg::THREAD_ID_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mfq_req_if.sink   req,
    mfq_rsp_if.source rsp
);
    import mfq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Queue RAM port signals. The waiters live in a ring: head pointer plus
    // count in the sequencer, entries in the RAM.
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [THREAD_ID_BITS-1:0] ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [THREAD_ID_BITS-1:0] ram_rdata;

    // Result hand-off from sequencer to the output register.
    logic res_valid;
    logic res_ready;
    res_t res;

    // Queue storage. Read data is registered and holds while no read is
    // issued, so a stalled result built from it stays put.
    mfq_queue_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (THREAD_ID_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: lock flag, head/count, and the walks over the queue RAM.
    //  - lock appends at the tail in the transfer cycle
    //  - unlock reads the head, advances it and reports the waiter
    //  - remove searches one entry per cycle, then moves the later
    //    entries up one place, one read and one write per cycle
    //  - destroy reads out every waiter in order, one result per cycle unless stalled
    mfq_seq #(
        .DEPTH (QUEUE_DEPTH),
        .IDW   (THREAD_ID_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: a finished result is presented here while the next request is taken;
    // while it is stalled, the sequencer and the request ready stall with it.
    mfq_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_res   (res),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/core/mfq_checker.sv =====
// ----------------------------------------------------------------------------
// Mutex wait queue checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "mutex_fifo_wait_queue_core_defines.svh"

module mfq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [mfq_pkg::STATUS_W-1:0] rsp_status,
    input logic                         rsp_thread_valid,
    input logic [mfq_pkg::TID_W-1:0]    rsp_thread_out,
    input logic                         rsp_last
);
    import mfq_pkg::*;

    // a stalled result holds
    `MFQ_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_thread_out) && $stable(rsp_last))

    // only destroy yields more than one result
    `MFQ_ASSERT_IMP(a_nonlast_term, clk, rst_n, rsp_valid && !rsp_last, rsp_status == ST_TERM && rsp_thread_valid)

    // a named thread comes only with wakeup or termination
    `MFQ_ASSERT_IMP(a_thread_status, clk, rst_n, rsp_valid && rsp_thread_valid, rsp_status == ST_DONE || rsp_status == ST_TERM)

    // no thread named means a zero id
    `MFQ_ASSERT_IMP(a_thread_zero, clk, rst_n, rsp_valid && !rsp_thread_valid, rsp_thread_out == '0)

endmodule

bind mutex_fifo_wait_queue_core mfq_checker u_mfq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_thread_valid (rsp.thread_valid),
    .rsp_thread_out   (rsp.thread_out),
    .rsp_last         (rsp.last)
);

// ===== dv/tb_mutex_fifo_wait_queue_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mutex wait queue core testbench
// Drives mutex requests through the request channel and scores every result
// against a cycle-free predictor of the mutex and its FIFO of waiters. Runs a
// directed pass, then random lock traffic under several idle patterns, and
// a long result-side hold that backs the block up into its request input.
// ----------------------------------------------------------------------------
module tb_mutex_fifo_wait_queue_core;
    import mfq_pkg::*;

    localparam int QDEPTH     = QUEUE_DEPTH_DEF;
    localparam int HOLD_LEN   = 300;        // result-side hold for the backpressure phase
    localparam int PHASE_REQS = 45;         // counted requests per idle phase
    localparam int DRAIN_LEN  = QDEPTH + 24; // beyond the longest remove walk

    // Action codes the package leaves undefined; the block must ignore them.
    localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

    typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_e;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TID_W-1:0]    tid;
    } request_t;

    logic clk;
    logic rst_n;

    mfq_req_if req ();
    mfq_rsp_if rsp ();

    mutex_fifo_wait_queue_core #(
        .QUEUE_DEPTH    (QDEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state: the mutex flag and the waiter FIFO, head at index 0.
    // ------------------------------------------------------------------
    logic             mtx_free;
    logic [TID_W-1:0] waiters[$];

    request_t request_q[$];   // requests not yet offered on the channel
    res_t     outcome_q[$];   // results owed by the block, oldest first

    gap_mode_e gap_mode;
    logic      rx_hold;        // forces ready low during the backpressure phase
    logic      rx_hold_go;

    int unsigned queued_items;
    int unsigned mismatch_count;
    int unsigned n_requests, n_results, n_queued, n_full, n_notfound;
    int unsigned n_woken, n_terminated;

    request_t drv_item;
    res_t     mon_want;

    // ------------------------------------------------------------------
    // Scoring
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic owe_result(input status_e st, input logic tv,
                              input logic [TID_W-1:0] t, input logic lst);
        res_t r;
        r.status       = st;
        r.thread_valid = tv;
        r.thread_out   = t;
        r.last         = lst;
        outcome_q.push_back(r);
    endtask

    // Applies one accepted request to the predictor and queues what the
    // block owes for it. Every request owes at least one result.
    task automatic mutex_outcome(input logic [ACTION_W-1:0] act,
                                 input logic [TID_W-1:0] tid);
        int hit;
        int cnt;
        hit = -1;
        n_requests++;
        case (act)
            ACT_INIT:
            begin
                mtx_free = 1'b1;
                waiters.delete();
                owe_result(ST_DONE, 1'b0, '0, 1'b1);
            end
            ACT_TRYLOCK:
            begin
                if (mtx_free)
                begin
                    mtx_free = 1'b0;
                    owe_result(ST_DONE, 1'b0, '0, 1'b1);
                end
                else
                    owe_result(ST_BUSY, 1'b0, '0, 1'b1);
            end
            ACT_LOCK:
            begin
                if (mtx_free)
                begin
                    mtx_free = 1'b0;
                    owe_result(ST_DONE, 1'b0, '0, 1'b1);
                end
                else if (waiters.size() < QDEPTH)
                begin
                    waiters.push_back(tid);
                    n_queued++;
                    owe_result(ST_QUEUED, 1'b0, '0, 1'b1);
                end
                else
                begin
                    n_full++;
                    owe_result(ST_FULL, 1'b0, '0, 1'b1);
                end
            end
            ACT_UNLOCK:
            begin
                // flag only, a second unlock leaves it free
                mtx_free = 1'b1;
                if (waiters.size() > 0)
                begin
                    n_woken++;
                    owe_result(ST_DONE, 1'b1, waiters.pop_front(), 1'b1);
                end
                else
                    owe_result(ST_DONE, 1'b0, '0, 1'b1);
            end
            ACT_REMOVE:
            begin
                // first match only, head treated like any other entry
                for (int i = 0; i < waiters.size() && hit < 0; i++)
                    if (waiters[i] == tid)
                        hit = i;
                if (hit >= 0)
                begin
                    waiters.delete(hit);
                    owe_result(ST_DONE, 1'b0, '0, 1'b1);
                end
                else
                begin
                    n_notfound++;
                    owe_result(ST_NOTFOUND, 1'b0, '0, 1'b1);
                end
            end
            ACT_DESTROY:
            begin
                cnt = waiters.size();
                if (cnt == 0)
                    owe_result(ST_DONE, 1'b0, '0, 1'b1);
                for (int i = 0; i < cnt; i++)
                    owe_result(ST_TERM, 1'b1, waiters[i], i == cnt - 1);
                n_terminated += cnt;
                waiters.delete();
                mtx_free = 1'b0;   // destroy leaves the mutex held
            end
            default:
                owe_result(ST_DONE, 1'b0, '0, 1'b1);
        endcase
    endtask

    task automatic score_result();
        if (outcome_q.size() == 0)
        begin
            flag_error($sformatf("result with nothing owed: status %0d thread %0d/%0h last %0d",
                                 rsp.status, rsp.thread_valid, rsp.thread_out, rsp.last));
            return;
        end
        mon_want = outcome_q.pop_front();
        n_results++;
        if (rsp.status !== mon_want.status)
            flag_error($sformatf("status got %0d want %0d", rsp.status, mon_want.status));
        if (rsp.thread_valid !== mon_want.thread_valid)
            flag_error($sformatf("thread_valid got %0b want %0b",
                                 rsp.thread_valid, mon_want.thread_valid));
        if (rsp.thread_out !== mon_want.thread_out)
            flag_error($sformatf("thread_out got %0h want %0h",
                                 rsp.thread_out, mon_want.thread_out));
        if (rsp.last !== mon_want.last)
            flag_error($sformatf("last got %0b want %0b", rsp.last, mon_want.last));
    endtask

    // ------------------------------------------------------------------
    // Idle patterns
    // ------------------------------------------------------------------
    function automatic logic sender_gap();
        case (gap_mode)
            GAP_SENDER: return $urandom_range(0, 99) < 62;
            GAP_BOTH:   return $urandom_range(0, 99) < 18;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_ready();
        if (rx_hold)
            return 1'b0;
        case (gap_mode)
            GAP_RECEIVER: return $urandom_range(0, 99) >= 62;
            GAP_BOTH:     return $urandom_range(0, 99) >= 18;
            default:      return 1'b1;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: the predictor runs on the transfer itself, then the next
    // pending request goes out unless the sender takes a gap. Valid is only
    // lowered when the channel is free.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.action    <= '0;
            req.thread_id <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                mutex_outcome(req.action, req.thread_id);
            if (!req.valid || req.ready)
            begin
                if (request_q.size() > 0 && !sender_gap())
                begin
                    drv_item = request_q.pop_front();
                    req.valid     <= 1'b1;
                    req.action    <= drv_item.action;
                    req.thread_id <= drv_item.tid;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor: scores each result transfer, then picks next cycle's ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
                score_result();
            rsp.ready <= receiver_ready();
        end
    end

    // Backpressure hold, counted here so the stimulus keeps flowing.
    initial
    begin
        rx_hold = 1'b0;
        wait (rx_hold_go === 1'b1);
        @(negedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus building blocks
    // ------------------------------------------------------------------
    task automatic add_request(input logic [ACTION_W-1:0] act, input logic [TID_W-1:0] tid);
        request_t r;
        r.action = act;
        r.tid    = tid;
        request_q.push_back(r);
        if (act <= ACT_DESTROY)
            queued_items++;
    endtask

    // Mostly random ids, with the extremes and a tiny pool that makes
    // duplicate waiters (remove must take the first one).
    function automatic logic [TID_W-1:0] pick_tid();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll < 4)
            return TID_W'($urandom_range(0, 3));
        return TID_W'($urandom);
    endfunction

    // Typical contention: an owner, a few waiters, then removes, wakes
    // and retries, closed by a destroy or an unlock chain.
    task automatic gen_contention();
        logic [TID_W-1:0] ids[$];
        logic [TID_W-1:0] t;
        if ($urandom_range(0, 3) == 0)
            add_request(ACT_INIT, pick_tid());
        add_request($urandom_range(0, 1) ? ACT_LOCK : ACT_TRYLOCK, pick_tid());
        repeat ($urandom_range(1, 8))
        begin
            t = pick_tid();
            ids.push_back(t);
            add_request(ACT_LOCK, t);
        end
        repeat ($urandom_range(2, 8))
        begin
            case ($urandom_range(0, 5))
                0, 1:
                    if ($urandom_range(0, 3) != 0)
                        add_request(ACT_REMOVE, ids[$urandom_range(0, ids.size() - 1)]);
                    else
                        add_request(ACT_REMOVE, pick_tid());
                2: add_request(ACT_UNLOCK, pick_tid());
                3: add_request(ACT_TRYLOCK, pick_tid());
                default:
                begin
                    t = pick_tid();
                    ids.push_back(t);
                    add_request(ACT_LOCK, t);
                end
            endcase
        end
        if ($urandom_range(0, 1))
            add_request(ACT_DESTROY, pick_tid());
        else
            repeat ($urandom_range(1, 4)) add_request(ACT_UNLOCK, pick_tid());
    endtask

    // Drive the wait queue past full, shuffle it a little, then destroy so
    // the longest result burst comes out.
    task automatic gen_overflow();
        logic [TID_W-1:0] ids[$];
        logic [TID_W-1:0] t;
        add_request(ACT_INIT, pick_tid());
        add_request(ACT_LOCK, pick_tid());
        repeat (QDEPTH + $urandom_range(1, 3))
        begin
            t = TID_W'($urandom);
            ids.push_back(t);
            add_request(ACT_LOCK, t);
        end
        repeat ($urandom_range(0, 3))
            add_request(ACT_REMOVE, ids[$urandom_range(0, ids.size() - 1)]);
        repeat ($urandom_range(0, 2))
            add_request(ACT_UNLOCK, pick_tid());
        repeat ($urandom_range(0, 4))
            add_request(ACT_LOCK, TID_W'($urandom));
        add_request(ACT_DESTROY, pick_tid());
    endtask

    // Unstructured traffic, undefined action codes included.
    task automatic gen_noise();
        repeat ($urandom_range(3, 8))
            add_request(ACTION_W'($urandom_range(0, 7)), TID_W'($urandom));
    endtask

    task automatic gen_random();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            gen_contention();
        else if (roll < 8)
            gen_overflow();
        else
            gen_noise();
    endtask

    // Wait until every request has gone out and every owed result is back.
    // Each request owes a result, so the block is idle at that point.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (request_q.size() > 0 || req.valid || outcome_q.size() > 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        req.valid      = 1'b0;
        req.action     = '0;
        req.thread_id  = '0;
        rsp.ready      = 1'b0;
        rx_hold_go     = 1'b0;
        gap_mode       = GAP_NONE;
        mtx_free       = 1'b1;
        queued_items   = 0;
        mismatch_count = 0;
        n_requests     = 0;
        n_results      = 0;
        n_queued       = 0;
        n_full         = 0;
        n_notfound     = 0;
        n_woken        = 0;
        n_terminated   = 0;

        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pass: grant and busy, duplicate waiters, remove at the
        // head, in the middle and with no match, wake order, unlock while
        // already free, destroy empty and with waiters, undefined codes.
        add_request(ACT_INIT,    8'h00);
        add_request(ACT_TRYLOCK, 8'h11);
        add_request(ACT_TRYLOCK, 8'h22);
        add_request(ACT_LOCK,    8'h00);
        add_request(ACT_LOCK,    8'hFF);
        add_request(ACT_LOCK,    8'h5A);
        add_request(ACT_LOCK,    8'hFF);
        add_request(ACT_REMOVE,  8'hFF);   // first of two copies goes
        add_request(ACT_REMOVE,  8'h00);   // head entry
        add_request(ACT_REMOVE,  8'h33);   // not queued
        add_request(ACT_UNLOCK,  8'h00);   // wakes 5A
        add_request(ACT_UNLOCK,  8'h00);   // wakes FF
        add_request(ACT_UNLOCK,  8'hFF);   // queue empty
        add_request(ACT_UNLOCK,  8'hFF);   // already free
        add_request(ACT_LOCK,    8'hA5);
        add_request(ACT_DESTROY, 8'h00);   // empty queue, mutex stays held
        add_request(ACT_TRYLOCK, 8'h01);
        add_request(ACT_LOCK,    8'h01);
        add_request(ACT_LOCK,    8'h80);
        add_request(ACT_DESTROY, 8'hFF);   // two terminated waiters
        add_request(ACT_RSVD6,   8'h7F);
        add_request(ACT_RSVD7,   8'h80);
        add_request(ACT_INIT,    8'hFF);
        add_request(ACT_REMOVE,  8'h00);   // empty queue
        wait_quiet();

        // Random traffic, one idle pattern per phase.
        queued_items = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            gap_mode = gap_mode_e'(ph);
            while (queued_items < PHASE_REQS * (ph + 1))
                gen_random();
            wait_quiet();
        end

        // Backpressure: results are held off while the sender keeps going,
        // so the block must fill up and drop its request ready.
        gap_mode   = GAP_NONE;
        rx_hold_go = 1'b1;
        gen_overflow();
        gen_contention();
        wait_quiet();

        repeat (DRAIN_LEN) @(posedge clk);
        @(negedge clk);
        if (outcome_q.size() > 0)
            flag_error($sformatf("%0d results never arrived", outcome_q.size()));

        $display("Covered %0d requests and %0d results: %0d queued, %0d queue full, %0d not found",
                 n_requests, n_results, n_queued, n_full, n_notfound);
        $display("Waiters woken by unlock: %0d, terminated by destroy: %0d, mismatches: %0d",
                 n_woken, n_terminated, mismatch_count);
        if (mismatch_count == 0)
            $display("mutex_fifo_wait_queue_core verification clean");
        else
            $display("mutex_fifo_wait_queue_core verification failed");
        $finish;
    end

    // Run limit, several times the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d requests pending, %0d results owed",
                 request_q.size(), outcome_q.size());
        $display("mutex_fifo_wait_queue_core verification failed");
        $finish;
    end

endmodule

// ===== mutex_fifo_wait_queue_core.f =====
+incdir+rtl/core
rtl/core/mfq_pkg.sv
rtl/core/mfq_req_if.sv
rtl/core/mfq_rsp_if.sv
rtl/core/mfq_queue_ram.sv
rtl/core/mfq_seq.sv
rtl/core/mfq_out_buf.sv
rtl/core/mutex_fifo_wait_queue_core.sv
rtl/core/mfq_checker.sv
dv/tb_mutex_fifo_wait_queue_core.sv
